// ----- rtl/ancf_pkg.sv -----
package ancf_pkg;

    // coordinate format
    localparam int CRD_W    = 32;
    localparam int T_BITS   = 30;
    localparam int CORNERS  = 8;
    localparam int CRN_AW   = $clog2(CORNERS);
    localparam int BOX_TRIS = 12;
    localparam int N_PLANES = 4;
    localparam int STK_DEPTH = 4;
    localparam int STK_AW   = $clog2(STK_DEPTH);
    localparam int LVL_W    = 3;
    localparam int JQ_DEPTH = 2;
    localparam int JQ_AW    = $clog2(JQ_DEPTH);

    // stream widths
    localparam int S_DATA_W = 7 * CRD_W;
    localparam int M_DATA_W = 2 * CRD_W;

    localparam logic [LVL_W-1:0] LVL_LEAF = LVL_W'(N_PLANES);
    localparam logic signed [CRD_W-1:0] CRD_MAX = {1'b0, {(CRD_W-1){1'b1}}};
    localparam logic signed [CRD_W-1:0] CRD_MIN = {1'b1, {(CRD_W-1){1'b0}}};

    typedef logic signed [CRD_W-1:0] crd_t;

    typedef struct packed {
        crd_t z;
        crd_t y;
        crd_t x;
    } vtx_t;

    // window lines: [0] min x, [1] max x, [2] min y, [3] max y
    typedef logic [N_PLANES-1:0][CRD_W-1:0] bnd_t;

    // pending triangle on the clip stack
    typedef struct packed {
        logic [LVL_W-1:0] lvl;
        vtx_t             p2;
        vtx_t             p1;
        vtx_t             p0;
    } stk_t;

    // corner indices of the 12 box triangles
    localparam logic [CRN_AW-1:0] BOX_IDX [0:3*BOX_TRIS-1] = '{
        3'd0, 3'd1, 3'd2,  3'd1, 3'd2, 3'd3,
        3'd4, 3'd5, 3'd6,  3'd5, 3'd6, 3'd7,
        3'd0, 3'd2, 3'd4,  3'd2, 3'd4, 3'd6,
        3'd1, 3'd3, 3'd5,  3'd3, 3'd5, 3'd7,
        3'd0, 3'd1, 3'd4,  3'd1, 3'd4, 3'd5,
        3'd2, 3'd3, 3'd6,  3'd3, 3'd6, 3'd7
    };

    // coordinate of a vertex by axis number
    function automatic crd_t vget(vtx_t v, logic [1:0] k);
        case (k)
            2'd0:    return v.x;
            2'd1:    return v.y;
            default: return v.z;
        endcase
    endfunction

endpackage

// ----- rtl/ancf_ram.sv -----
module ancf_ram #(
    parameter int W = 8,
    parameter int D = 4
) (
    input  logic                 clk,
    input  logic                 we,
    input  logic [$clog2(D)-1:0] waddr,
    input  logic [W-1:0]         wdata,
    input  logic [$clog2(D)-1:0] raddr,
    output logic [W-1:0]         rdata
);

    logic [W-1:0] mem_reg [D];
    logic [W-1:0] rdata_reg;

    // one write port, one registered read port
    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem_reg[waddr] <= wdata;
        end
        rdata_reg <= mem_reg[raddr];
    end

    assign rdata = rdata_reg;

endmodule

// ----- rtl/ancf_front.sv -----
module ancf_front (
    input  logic                            clk,
    input  logic                            rst_n,
    input  logic                            s_tvalid,
    output logic                            s_tready,
    input  logic [ancf_pkg::S_DATA_W-1:0]   s_tdata,
    input  logic                            s_tlast,
    input  logic                            hold,
    output logic                            job_push,
    output ancf_pkg::bnd_t                  job_bnd,
    input  logic [ancf_pkg::CRN_AW-1:0]     crn_raddr,
    output ancf_pkg::vtx_t                  crn_rdata
);
    import ancf_pkg::*;

    logic              acc;
    logic [CRN_AW-1:0] count_reg;

    assign s_tready = !hold;
    assign acc      = s_tvalid && s_tready;
    assign job_push = acc && s_tlast;
    assign job_bnd  = s_tdata[S_DATA_W-1:3*CRD_W];

    // slot for the next corner; a last corner restarts at slot 0
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            count_reg <= '0;
        end
        else if (acc)
        begin
            count_reg <= s_tlast ? '0 : count_reg + 1'b1;
        end
    end

    // corner store
    ancf_ram #(
        .W ($bits(vtx_t)),
        .D (CORNERS)
    ) u_crn (
        .clk   (clk),
        .we    (acc),
        .waddr (count_reg),
        .wdata (s_tdata[3*CRD_W-1:0]),
        .raddr (crn_raddr),
        .rdata (crn_rdata)
    );

endmodule

// ----- rtl/ancf_jobq.sv -----
module ancf_jobq (
    input  logic           clk,
    input  logic           rst_n,
    input  logic           push,
    input  ancf_pkg::bnd_t push_bnd,
    input  logic           pop,
    output logic           valid,
    output ancf_pkg::bnd_t head
);
    import ancf_pkg::*;

    bnd_t             ent_reg [JQ_DEPTH];
    logic [JQ_AW-1:0] wr_reg;
    logic [JQ_AW-1:0] rd_reg;
    logic [JQ_AW:0]   cnt_reg;

    assign valid = (cnt_reg != '0);
    assign head  = ent_reg[rd_reg];

    // pointers and fill level
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_reg  <= '0;
            rd_reg  <= '0;
            cnt_reg <= '0;
        end
        else
        begin
            if (push)
            begin
                wr_reg <= wr_reg + 1'b1;
            end
            if (pop)
            begin
                rd_reg <= rd_reg + 1'b1;
            end
            case ({push, pop})
                2'b10:   cnt_reg <= cnt_reg + 1'b1;
                2'b01:   cnt_reg <= cnt_reg - 1'b1;
                default: cnt_reg <= cnt_reg;
            endcase
        end
    end

    // entries
    always_ff @(posedge clk)
    begin
        if (push)
        begin
            ent_reg[wr_reg] <= push_bnd;
        end
    end

endmodule

// ----- rtl/ancf_cut.sv -----
module ancf_cut (
    input  logic           clk,
    input  logic           rst_n,
    input  logic           start,
    input  ancf_pkg::vtx_t a,
    input  ancf_pkg::vtx_t b,
    input  logic           axis,
    input  ancf_pkg::crd_t line_pos,
    output logic           done,
    output ancf_pkg::vtx_t res
);
    import ancf_pkg::*;

    typedef enum logic [2:0] {
        C_IDLE = 3'b001,
        C_DIV  = 3'b010,
        C_MUL  = 3'b100
    } cst_t;

    cst_t              state_reg;
    logic [4:0]        it_reg;
    logic [1:0]        k_reg;
    logic [2:0]        ph_reg;
    logic              done_reg;
    logic [32:0]       ud_reg;
    logic [32:0]       r_reg;
    logic [T_BITS:0]   q_reg;
    logic [32:0]       mag_reg;
    logic              neg_reg;
    logic [47:0]       prod_reg;
    logic [47:0]       acc_reg;
    logic [32:0]       off_reg;
    vtx_t              res_reg;

    crd_t              ac;
    crd_t              bc;
    logic signed [32:0] dn;
    logic signed [32:0] dd;
    logic [32:0]       un;
    logic [32:0]       ud;
    logic [32:0]       unc;
    logic [33:0]       r2;
    logic              ge;
    crd_t              ak;
    crd_t              bk;
    logic signed [32:0] dk;
    logic [16:0]       mul_a;
    logic [47:0]       mul_p;
    logic [63:0]       sum;
    crd_t              rk;

    // setup: distances along the clipped axis
    assign ac  = axis ? a.y : a.x;
    assign bc  = axis ? b.y : b.x;
    assign dn  = {line_pos[CRD_W-1], line_pos} - {ac[CRD_W-1], ac};
    assign dd  = {bc[CRD_W-1], bc} - {ac[CRD_W-1], ac};
    assign un  = dn[32] ? 33'(-dn) : 33'(dn);
    assign ud  = dd[32] ? 33'(-dd) : 33'(dd);
    assign unc = (un > ud) ? ud : un;

    // restoring division, one quotient bit a cycle
    assign r2 = {r_reg, 1'b0};
    assign ge = (r2 >= {1'b0, ud_reg});

    // per-axis offset: |B-A| * t in two partial products
    assign ak    = vget(a, k_reg);
    assign bk    = vget(b, k_reg);
    assign dk    = {bk[CRD_W-1], bk} - {ak[CRD_W-1], ak};
    assign mul_a = (ph_reg == 3'd1) ? {1'b0, mag_reg[15:0]} : mag_reg[32:16];
    assign mul_p = mul_a * q_reg;
    assign sum   = 64'(acc_reg) + {prod_reg, 16'b0} + (64'd1 << (T_BITS - 1));
    assign rk    = neg_reg ? ak - crd_t'(off_reg[CRD_W-1:0])
                           : ak + crd_t'(off_reg[CRD_W-1:0]);

    // sequencer
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= C_IDLE;
            it_reg    <= '0;
            k_reg     <= '0;
            ph_reg    <= '0;
            done_reg  <= 1'b0;
        end
        else
        begin
            // pulse after the last axis is written
            done_reg <= (state_reg == C_MUL) && (ph_reg == 3'd4) && (k_reg == 2'd2);
            unique case (state_reg)
                C_IDLE:
                begin
                    if (start)
                    begin
                        it_reg    <= '0;
                        k_reg     <= '0;
                        ph_reg    <= '0;
                        state_reg <= (ud == '0) ? C_MUL : C_DIV;
                    end
                end
                C_DIV:
                begin
                    it_reg <= it_reg + 1'b1;
                    if (it_reg == 5'(T_BITS - 1))
                    begin
                        state_reg <= C_MUL;
                    end
                end
                C_MUL:
                begin
                    if (ph_reg == 3'd4)
                    begin
                        ph_reg <= '0;
                        k_reg  <= k_reg + 1'b1;
                        if (k_reg == 2'd2)
                        begin
                            state_reg <= C_IDLE;
                        end
                    end
                    else
                    begin
                        ph_reg <= ph_reg + 1'b1;
                    end
                end
                default:
                begin
                    state_reg <= C_IDLE;
                end
            endcase
        end
    end

    // datapath
    always_ff @(posedge clk)
    begin
        case (state_reg)
            C_IDLE:
            begin
                if (start)
                begin
                    ud_reg <= ud;
                    if (ud == '0)
                    begin
                        q_reg <= '0;
                        r_reg <= '0;
                    end
                    else if (unc == ud)
                    begin
                        q_reg <= (T_BITS+1)'(1);
                        r_reg <= '0;
                    end
                    else
                    begin
                        q_reg <= '0;
                        r_reg <= unc;
                    end
                end
            end
            C_DIV:
            begin
                r_reg <= ge ? 33'(r2 - {1'b0, ud_reg}) : r2[32:0];
                q_reg <= {q_reg[T_BITS-1:0], ge};
            end
            C_MUL:
            begin
                case (ph_reg)
                    3'd0:
                    begin
                        mag_reg <= dk[32] ? 33'(-dk) : 33'(dk);
                        neg_reg <= dk[32];
                    end
                    3'd1:
                    begin
                        prod_reg <= mul_p;
                    end
                    3'd2:
                    begin
                        acc_reg  <= prod_reg;
                        prod_reg <= mul_p;
                    end
                    3'd3:
                    begin
                        off_reg <= sum[62:T_BITS];
                    end
                    default:
                    begin
                        case (k_reg)
                            2'd0:    res_reg.x <= rk;
                            2'd1:    res_reg.y <= rk;
                            default: res_reg.z <= rk;
                        endcase
                    end
                endcase
            end
            default:
            begin
                r_reg <= r_reg;
            end
        endcase
    end

    assign done = done_reg;
    assign res  = res_reg;

endmodule

// ----- rtl/ancf_clip.sv -----
module ancf_clip (
    input  logic                            clk,
    input  logic                            rst_n,
    input  logic                            job_valid,
    input  ancf_pkg::bnd_t                  job_bnd,
    output logic                            job_pop,
    output logic                            crn_busy,
    output logic [ancf_pkg::CRN_AW-1:0]     crn_raddr,
    input  ancf_pkg::vtx_t                  crn_rdata,
    output logic                            m_tvalid,
    input  logic                            m_tready,
    output logic [ancf_pkg::M_DATA_W-1:0]   m_tdata,
    output logic                            m_tuser
);
    import ancf_pkg::*;

    typedef enum logic [9:0] {
        B_IDLE  = 10'b0000000001,
        B_COPY  = 10'b0000000010,
        B_LOAD  = 10'b0000000100,
        B_CLASS = 10'b0000001000,
        B_CUT   = 10'b0000010000,
        B_FIN   = 10'b0000100000,
        B_ACC   = 10'b0001000000,
        B_POP   = 10'b0010000000,
        B_POPW  = 10'b0100000000,
        B_DONE  = 10'b1000000000
    } bst_t;

    bst_t              state_reg;
    logic [CRN_AW:0]   cp_reg;
    logic [3:0]        tri_reg;
    logic [1:0]        ldk_reg;
    logic [LVL_W-1:0]  lvl_reg;
    logic [STK_AW:0]   sp_reg;
    logic              sel_reg;
    logic              run_reg;
    logic [1:0]        acck_reg;
    logic              out_valid_reg;

    bnd_t              bnd_reg;
    vtx_t              v0_reg;
    vtx_t              v1_reg;
    vtx_t              v2_reg;
    logic              split_reg;
    vtx_t              ca_reg;
    vtx_t              cb_reg;
    crd_t              near_reg;
    crd_t              far_reg;
    logic              any_reg;
    crd_t              out_near_reg;
    crd_t              out_far_reg;
    logic              out_empty_reg;

    logic [5:0]        bidx;
    vtx_t              lc_rdata;
    stk_t              stk_wdata;
    stk_t              stk_rdata;
    logic              stk_we;
    crd_t              line_pos;
    logic              axis;
    logic [2:0]        flags;
    logic              two_in;
    logic              cut_start;
    logic              cut_done;
    vtx_t              cut_res;
    vtx_t              cut_a;
    vtx_t              cut_b;
    crd_t              zk;
    logic              out_load;

    // corner copy from the front store
    assign crn_busy  = (state_reg == B_COPY);
    assign crn_raddr = cp_reg[CRN_AW-1:0];
    assign job_pop   = (state_reg == B_IDLE) && job_valid;

    ancf_ram #(
        .W ($bits(vtx_t)),
        .D (CORNERS)
    ) u_lcrn (
        .clk   (clk),
        .we    ((state_reg == B_COPY) && (cp_reg != '0)),
        .waddr (CRN_AW'(cp_reg - 1'b1)),
        .wdata (crn_rdata),
        .raddr (BOX_IDX[bidx]),
        .rdata (lc_rdata)
    );

    assign bidx = 6'(tri_reg) * 6'd3 + 6'(ldk_reg);

    // stack of pending split halves
    assign stk_we          = (state_reg == B_FIN) && split_reg;
    assign stk_wdata.lvl   = lvl_reg + 1'b1;
    assign stk_wdata.p0    = v0_reg;
    assign stk_wdata.p1    = v1_reg;
    assign stk_wdata.p2    = ca_reg;

    ancf_ram #(
        .W ($bits(stk_t)),
        .D (STK_DEPTH)
    ) u_stk (
        .clk   (clk),
        .we    (stk_we),
        .waddr (sp_reg[STK_AW-1:0]),
        .wdata (stk_wdata),
        .raddr (STK_AW'(sp_reg - 1'b1)),
        .rdata (stk_rdata)
    );

    // strict inside test against the current line
    assign line_pos = crd_t'(bnd_reg[lvl_reg[1:0]]);
    assign axis     = lvl_reg[1];

    function automatic logic inside_f(vtx_t v, logic ax, logic lt, crd_t lp);
        crd_t c;
        c = ax ? v.y : v.x;
        return lt ? (c < lp) : (c > lp);
    endfunction

    assign flags[0] = inside_f(v0_reg, axis, lvl_reg[0], line_pos);
    assign flags[1] = inside_f(v1_reg, axis, lvl_reg[0], line_pos);
    assign flags[2] = inside_f(v2_reg, axis, lvl_reg[0], line_pos);
    assign two_in   = (flags[0] & flags[1]) | (flags[0] & flags[2]) | (flags[1] & flags[2]);

    // edge cuts: one inside uses v0 as origin, two inside use v2
    assign cut_start = (state_reg == B_CUT) && !run_reg;
    assign cut_a     = split_reg ? v2_reg : v0_reg;
    assign cut_b     = sel_reg ? (split_reg ? v1_reg : v2_reg)
                               : (split_reg ? v0_reg : v1_reg);

    ancf_cut u_cut (
        .clk      (clk),
        .rst_n    (rst_n),
        .start    (cut_start),
        .a        (cut_a),
        .b        (cut_b),
        .axis     (axis),
        .line_pos (line_pos),
        .done     (cut_done),
        .res      (cut_res)
    );

    assign zk = (acck_reg == 2'd0) ? v0_reg.z : ((acck_reg == 2'd1) ? v1_reg.z : v2_reg.z);

    assign out_load = (state_reg == B_DONE) && (!out_valid_reg || m_tready);

    // control
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= B_IDLE;
            cp_reg        <= '0;
            tri_reg       <= '0;
            ldk_reg       <= '0;
            lvl_reg       <= '0;
            sp_reg        <= '0;
            sel_reg       <= 1'b0;
            run_reg       <= 1'b0;
            acck_reg      <= '0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            if (out_load)
            begin
                out_valid_reg <= 1'b1;
            end
            else if (m_tready)
            begin
                out_valid_reg <= 1'b0;
            end

            unique case (state_reg)
                B_IDLE:
                begin
                    if (job_valid)
                    begin
                        cp_reg    <= '0;
                        state_reg <= B_COPY;
                    end
                end
                B_COPY:
                begin
                    cp_reg <= cp_reg + 1'b1;
                    if (cp_reg == (CRN_AW+1)'(CORNERS))
                    begin
                        tri_reg   <= '0;
                        ldk_reg   <= '0;
                        sp_reg    <= '0;
                        state_reg <= B_LOAD;
                    end
                end
                B_LOAD:
                begin
                    ldk_reg <= ldk_reg + 1'b1;
                    if (ldk_reg == 2'd3)
                    begin
                        lvl_reg   <= '0;
                        state_reg <= B_CLASS;
                    end
                end
                B_CLASS:
                begin
                    if (lvl_reg == LVL_LEAF)
                    begin
                        acck_reg  <= '0;
                        state_reg <= B_ACC;
                    end
                    else
                    begin
                        case (flags)
                            3'b000:
                            begin
                                state_reg <= B_POP;
                            end
                            3'b111:
                            begin
                                lvl_reg <= lvl_reg + 1'b1;
                            end
                            default:
                            begin
                                sel_reg   <= 1'b0;
                                run_reg   <= 1'b0;
                                state_reg <= B_CUT;
                            end
                        endcase
                    end
                end
                B_CUT:
                begin
                    if (cut_start)
                    begin
                        run_reg <= 1'b1;
                    end
                    if (cut_done)
                    begin
                        run_reg <= 1'b0;
                        sel_reg <= 1'b1;
                        if (sel_reg)
                        begin
                            state_reg <= B_FIN;
                        end
                    end
                end
                B_FIN:
                begin
                    if (split_reg)
                    begin
                        sp_reg <= sp_reg + 1'b1;
                    end
                    lvl_reg   <= lvl_reg + 1'b1;
                    state_reg <= B_CLASS;
                end
                B_ACC:
                begin
                    acck_reg <= acck_reg + 1'b1;
                    if (acck_reg == 2'd2)
                    begin
                        state_reg <= B_POP;
                    end
                end
                B_POP:
                begin
                    if (sp_reg == '0)
                    begin
                        if (tri_reg == 4'(BOX_TRIS - 1))
                        begin
                            state_reg <= B_DONE;
                        end
                        else
                        begin
                            tri_reg   <= tri_reg + 1'b1;
                            ldk_reg   <= '0;
                            state_reg <= B_LOAD;
                        end
                    end
                    else
                    begin
                        sp_reg    <= sp_reg - 1'b1;
                        state_reg <= B_POPW;
                    end
                end
                B_POPW:
                begin
                    lvl_reg   <= stk_rdata.lvl;
                    state_reg <= B_CLASS;
                end
                B_DONE:
                begin
                    if (out_load)
                    begin
                        state_reg <= B_IDLE;
                    end
                end
                default:
                begin
                    state_reg <= B_IDLE;
                end
            endcase
        end
    end

    // datapath
    always_ff @(posedge clk)
    begin
        case (state_reg)
            B_IDLE:
            begin
                if (job_valid)
                begin
                    bnd_reg  <= job_bnd;
                    near_reg <= CRD_MAX;
                    far_reg  <= CRD_MIN;
                    any_reg  <= 1'b0;
                end
            end
            B_LOAD:
            begin
                case (ldk_reg)
                    2'd1:    v0_reg <= lc_rdata;
                    2'd2:    v1_reg <= lc_rdata;
                    2'd3:    v2_reg <= lc_rdata;
                    default: v0_reg <= v0_reg;
                endcase
            end
            B_CLASS:
            begin
                // inside vertices first, each group in its old order
                split_reg <= two_in;
                case (flags)
                    3'b010:
                    begin
                        v0_reg <= v1_reg;
                        v1_reg <= v0_reg;
                    end
                    3'b100:
                    begin
                        v0_reg <= v2_reg;
                        v1_reg <= v0_reg;
                        v2_reg <= v1_reg;
                    end
                    3'b101:
                    begin
                        v1_reg <= v2_reg;
                        v2_reg <= v1_reg;
                    end
                    3'b110:
                    begin
                        v0_reg <= v1_reg;
                        v1_reg <= v2_reg;
                        v2_reg <= v0_reg;
                    end
                    default:
                    begin
                        v0_reg <= v0_reg;
                    end
                endcase
            end
            B_CUT:
            begin
                if (cut_done)
                begin
                    if (sel_reg)
                    begin
                        cb_reg <= cut_res;
                    end
                    else
                    begin
                        ca_reg <= cut_res;
                    end
                end
            end
            B_FIN:
            begin
                if (split_reg)
                begin
                    v0_reg <= v1_reg;
                    v1_reg <= ca_reg;
                    v2_reg <= cb_reg;
                end
                else
                begin
                    v1_reg <= cb_reg;
                    v2_reg <= ca_reg;
                end
            end
            B_ACC:
            begin
                any_reg <= 1'b1;
                if (zk < near_reg)
                begin
                    near_reg <= zk;
                end
                if (zk > far_reg)
                begin
                    far_reg <= zk;
                end
            end
            B_POPW:
            begin
                v0_reg <= stk_rdata.p0;
                v1_reg <= stk_rdata.p1;
                v2_reg <= stk_rdata.p2;
            end
            B_DONE:
            begin
                if (out_load)
                begin
                    out_near_reg  <= near_reg;
                    out_far_reg   <= far_reg;
                    out_empty_reg <= !any_reg;
                end
            end
            default:
            begin
                v0_reg <= v0_reg;
            end
        endcase
    end

    assign m_tvalid = out_valid_reg;
    assign m_tdata  = {out_far_reg, out_near_reg};
    assign m_tuser  = out_empty_reg;

endmodule

// ----- rtl/aabb_clip_near_far.sv -----
// Channel  Dir  Transfer                       Payload
// s_       in   one box corner (last: + lines) tdata, tlast = last_corner
// m_       out  one near/far result per box    tdata, tuser = all_culled
//
// Corners transfer one per cycle while s_tready is high. After the last corner the clip
// engine copies the corners, loads each box triangle and clips it line by line; a step
// that cuts edges makes two cut unit runs, each using the 30-step serial divider.
// Surviving pieces are accumulated, culled pieces dropped and stack entries popped.
// The next box streams in during clipping; input stalls from a last corner until the
// engine, free of the previous box and its held result, has copied that box.
// Reset clears all control state; corner and stack contents are not cleared.
module aabb_clip_near_far (
    input  logic                            clk,
    input  logic                            rst_n,
    input  logic                            s_tvalid,
    output logic                            s_tready,
    // point_x, point_y, point_z, bound_min_x, bound_max_x, bound_min_y, bound_max_y
    input  logic [ancf_pkg::S_DATA_W-1:0]   s_tdata,
    input  logic                            s_tlast,
    output logic                            m_tvalid,
    input  logic                            m_tready,
    // near_z, far_z
    output logic [ancf_pkg::M_DATA_W-1:0]   m_tdata,
    // all_culled
    output logic                            m_tuser
);
    import ancf_pkg::*;

    logic              job_push;
    bnd_t              job_bnd;
    logic              job_pop;
    logic              job_valid;
    bnd_t              job_head;
    logic              crn_busy;
    logic [CRN_AW-1:0] crn_raddr;
    vtx_t              crn_rdata;

    ancf_front u_front (
        .clk       (clk),
        .rst_n     (rst_n),
        .s_tvalid  (s_tvalid),
        .s_tready  (s_tready),
        .s_tdata   (s_tdata),
        .s_tlast   (s_tlast),
        .hold      (job_valid || crn_busy),
        .job_push  (job_push),
        .job_bnd   (job_bnd),
        .crn_raddr (crn_raddr),
        .crn_rdata (crn_rdata)
    );

    ancf_jobq u_jobq (
        .clk      (clk),
        .rst_n    (rst_n),
        .push     (job_push),
        .push_bnd (job_bnd),
        .pop      (job_pop),
        .valid    (job_valid),
        .head     (job_head)
    );

    ancf_clip u_clip (
        .clk       (clk),
        .rst_n     (rst_n),
        .job_valid (job_valid),
        .job_bnd   (job_head),
        .job_pop   (job_pop),
        .crn_busy  (crn_busy),
        .crn_raddr (crn_raddr),
        .crn_rdata (crn_rdata),
        .m_tvalid  (m_tvalid),
        .m_tready  (m_tready),
        .m_tdata   (m_tdata),
        .m_tuser   (m_tuser)
    );

endmodule
